[rtl/stqd_pkg.sv]
package stqd_pkg;

   // configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LAYOUT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CTX_A      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CTX_B      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CTX_C      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_Z     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_AXIS = 3'd5;

   // layout codes
   localparam logic [1:0] LAYOUT_OFFSET = 2'd0;
   localparam logic [1:0] LAYOUT_SIGNED = 2'd1;
   localparam logic [1:0] LAYOUT_TABLE  = 2'd2;

   // context rom bounds
   localparam logic [7:0] CTX_LOW  = 8'h9D;
   localparam logic [7:0] CTX_HIGH = 8'hFD;

   // register defaults
   localparam logic [7:0] CTX_RESET   = 8'd157;
   localparam logic [2:0] AXIS_RESET  = 3'b111;

   // fixed point constants, Q2.22 values and Q4.44 squares
   localparam int VAL_W = 25;
   localparam logic signed [23:0] K_Q22      = 24'sd2965821;
   localparam logic [49:0]        RENORM_MIN = 50'd175921;
   localparam logic [49:0]        ONE_SQ     = 50'd1 << 44;

   typedef logic signed [VAL_W-1:0] val_type;

endpackage

[rtl/stqd_div.sv]
module stqd_div #(
   parameter int LANES = 3,
   parameter int NW    = 42,
   parameter int DW    = 17,
   parameter int QW    = 24,
   parameter int SW    = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [LANES-1:0][NW-1:0]  in_num,
   input  logic [LANES-1:0][DW-1:0]  in_den,
   input  logic [SW-1:0]             in_side,
   output logic                      out_valid,
   output logic [LANES-1:0][QW-1:0]  out_quo,
   output logic [SW-1:0]             out_side
);

   logic                      valid_ff [QW];
   logic [LANES-1:0][NW-1:0]  rem_ff   [QW];
   logic [LANES-1:0][DW-1:0]  den_ff   [QW];
   logic [LANES-1:0][QW-1:0]  quo_ff   [QW];
   logic [SW-1:0]             side_ff  [QW];

   // one restoring quotient bit per stage, msb first
   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int Shift = QW - 1 - s;
      logic                     valid_prev;
      logic [LANES-1:0][NW-1:0] rem_prev;
      logic [LANES-1:0][NW-1:0] rem_in;
      logic [LANES-1:0][DW-1:0] den_prev;
      logic [LANES-1:0][QW-1:0] quo_prev;
      logic [LANES-1:0][QW-1:0] quo_in;
      logic [SW-1:0]            side_prev;

      if (s == 0) begin : g_head
         assign valid_prev = in_valid;
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quo_prev   = '0;
         assign side_prev  = in_side;
      end else begin : g_tail
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign quo_prev   = quo_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
         logic [NW-1:0] trial;
         rem_in = rem_prev;
         quo_in = quo_prev;
         for (int l = 0; l < LANES; l++) begin
            trial = NW'(den_prev[l]) << Shift;
            if (rem_prev[l] >= trial) begin
               rem_in[l]        = rem_prev[l] - trial;
               quo_in[l][Shift] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_prev;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

[rtl/stqd_sqrt.sv]
module stqd_sqrt #(
   parameter int W  = 46,
   parameter int SW = 77
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [W-1:0]    in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [W/2-1:0]  out_root,
   output logic [SW-1:0]   out_side
);

   localparam int RW = W / 2;

   logic            valid_ff [RW];
   logic [W-1:0]    rem_ff   [RW];
   logic [RW-1:0]   root_ff  [RW];
   logic [SW-1:0]   side_ff  [RW];

   // one root bit per stage, msb first
   for (genvar s = 0; s < RW; s++) begin : g_step
      localparam int Pos = RW - 1 - s;
      logic          valid_prev;
      logic [W-1:0]  rem_prev;
      logic [W-1:0]  rem_in;
      logic [RW-1:0] root_prev;
      logic [RW-1:0] root_in;
      logic [SW-1:0] side_prev;

      if (s == 0) begin : g_head
         assign valid_prev = in_valid;
         assign rem_prev   = in_rad;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_tail
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // (root + 2^pos)^2 fits when remainder covers 2*root*2^pos + 4^pos
      always_comb begin
         logic [W-1:0] trial;
         trial   = (W'(root_prev) << (Pos + 1)) | (W'(1) << (2 * Pos));
         rem_in  = rem_prev;
         root_in = root_prev;
         if (rem_prev >= trial) begin
            rem_in       = rem_prev - trial;
            root_in[Pos] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

[rtl/smallest_three_quaternion_decode.sv]
// one item per cycle sustained from input transfer to result while the result register is not held
// depth is set by the 24-step component divider, the 23-step and 32-step root
// chains and the 17-step normalizing divider, plus twelve stages of glue logic
// a held result freezes the whole pipeline; nothing is dropped or repeated
// reset is synchronous: clears all valid bits and loads the register defaults
module smallest_three_quaternion_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_packed_rotation,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_quat_x,
   output logic signed [15:0]                rsp_quat_y,
   output logic signed [15:0]                rsp_quat_z,
   output logic signed [15:0]                rsp_quat_w,
   input  logic                              csr_write,
   input  logic [stqd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stqd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import stqd_pkg::*;

   // configuration registers
   logic [1:0]      layout_ff;
   logic [2:0][7:0] ctx_ff;
   logic            skip_z_ff;
   logic [2:0]      force_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_TABLE;
         ctx_ff    <= {CTX_RESET, CTX_RESET, CTX_RESET};
         skip_z_ff <= 1'b0;
         force_ff  <= AXIS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_LAYOUT:     layout_ff <= csr_data[1:0];
            REG_CTX_A:      ctx_ff[0] <= csr_data;
            REG_CTX_B:      ctx_ff[1] <= csr_data;
            REG_CTX_C:      ctx_ff[2] <= csr_data;
            REG_SKIP_Z:     skip_z_ff <= csr_data[0];
            REG_FORCE_AXIS: force_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // pipeline moves as one unless the result register is held
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   function automatic logic [7:0] ctx_clamp(input logic [7:0] ctx);
      logic [7:0] c;
      c = ctx;
      if (c < CTX_LOW) c = CTX_LOW;
      if (c > CTX_HIGH) c = CTX_HIGH;
      return c;
   endfunction

   function automatic logic [2:0] ctx_level(input logic [7:0] c);
      logic [2:0] lvl;
      priority if (c >= 8'hFC) lvl = 3'd1;
      else if (c >= 8'hF8) lvl = 3'd2;
      else if (c >= 8'hF0) lvl = 3'd3;
      else if (c >= 8'hE0) lvl = 3'd4;
      else if (c >= 8'hC0) lvl = 3'd5;
      else lvl = 3'd6;
      return lvl;
   endfunction

   // stage 1: field decode into a signed numerator and divisor per component
   logic [2:0][41:0] num1_in, num1_ff;
   logic [2:0][16:0] den1_in, den1_ff;
   logic [1:0]       idx1_in, idx1_ff;
   logic             v1_ff;

   always_comb begin
      logic [7:0]         c;
      logic [2:0]         lvl;
      logic [8:0]         span;
      logic signed [9:0]  k;
      logic signed [9:0]  term;
      logic signed [19:0] base;
      logic signed [19:0] n2;
      logic signed [19:0] dmul;
      logic [16:0]        dden;
      logic signed [11:0] t;
      logic [9:0]         f;
      logic               neg;
      logic [9:0]         mag;
      // local defaults
      c    = '0;
      lvl  = '0;
      span = '0;
      k    = '0;
      term = '0;
      base = '0;
      n2   = '0;
      dmul = '0;
      dden = '0;
      t    = '0;
      f    = '0;
      neg  = 1'b0;
      mag  = '0;
      num1_in = '0;
      den1_in = '0;
      idx1_in = req_packed_rotation[31:30];
      unique case (layout_ff)
         LAYOUT_TABLE: begin
            idx1_in = force_ff[2] ? 2'd3 : force_ff[1:0];
            for (int j = 0; j < 3; j++) begin
               c    = ctx_clamp(ctx_ff[j]);
               lvl  = ctx_level(c);
               span = 9'd1 << lvl;
               if (j == 0) begin
                  neg = req_packed_rotation[31];
                  mag = req_packed_rotation[30:21];
               end else if (j == 1) begin
                  neg = req_packed_rotation[20];
                  mag = req_packed_rotation[19:10];
               end else begin
                  neg = req_packed_rotation[9];
                  mag = {1'b0, req_packed_rotation[8:0]};
               end
               dmul = (j == 2) ? 20'sd1023 : 20'sd511;
               dden = (j == 2) ? 17'd1023 : 17'd511;
               k    = $signed({2'b00, c}) - $signed(10'd256 - {span, 1'b0});
               term = (k <<< 1) - $signed({1'b0, span}) + 10'sd1;
               base = 20'(term) * dmul;
               n2   = neg ? base - $signed({9'd0, mag, 1'b0})
                          : base + $signed({9'd0, mag, 1'b0});
               num1_in[j] = {n2, 22'd0};
               den1_in[j] = ({8'd0, span} + 17'd1) * dden;
            end
         end
         LAYOUT_SIGNED: begin
            idx1_in = req_packed_rotation[1:0];
            for (int j = 0; j < 3; j++) begin
               f          = req_packed_rotation[2 + 10 * j +: 10];
               num1_in[j] = 42'($signed(f)) * 42'(K_Q22);
               den1_in[j] = 17'd512;
            end
         end
         default: begin
            // offset layout, also taken by the unused code
            for (int j = 0; j < 3; j++) begin
               f          = req_packed_rotation[10 * j +: 10];
               t          = $signed({1'b0, f, 1'b0}) - 12'sd1023;
               num1_in[j] = 42'(t) * 42'(K_Q22);
               den1_in[j] = 17'd1023;
            end
         end
      endcase
   end

   // stage 2: magnitude plus half divisor for round-half-away
   logic [2:0][41:0] nmag2_in, nmag2_ff;
   logic [2:0][16:0] den2_ff;
   logic [2:0]       neg2_in, neg2_ff;
   logic [1:0]       idx2_ff;
   logic             v2_ff;

   always_comb begin
      logic [41:0] m;
      for (int j = 0; j < 3; j++) begin
         m           = num1_ff[j][41] ? 42'(-$signed(num1_ff[j])) : num1_ff[j];
         nmag2_in[j] = m + 42'(den1_ff[j] >> 1);
         neg2_in[j]  = num1_ff[j][41];
      end
   end

   // component divider
   logic             q1_valid;
   logic [2:0][23:0] q1_quo;
   logic [4:0]       q1_side;
   logic [1:0]       q1_idx;
   logic [2:0]       q1_neg;

   stqd_div #(
      .LANES (3),
      .NW    (42),
      .DW    (17),
      .QW    (24),
      .SW    (5)
   ) u_comp_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v2_ff),
      .in_num    (nmag2_ff),
      .in_den    (den2_ff),
      .in_side   ({idx2_ff, neg2_ff}),
      .out_valid (q1_valid),
      .out_quo   (q1_quo),
      .out_side  (q1_side)
   );

   assign {q1_idx, q1_neg} = q1_side;

   // stage 3: signed Q2.22 components
   val_type [2:0] vals3_in, vals3_ff;
   logic [1:0]    idx3_ff;
   logic          v3_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         vals3_in[j] = q1_neg[j] ? 25'(-$signed({1'b0, q1_quo[j]})) : {1'b0, q1_quo[j]};
      end
   end

   // stage 4: squares in Q4.44
   logic [2:0][47:0] sq4_in, sq4_ff;
   val_type [2:0]    vals4_ff;
   logic [1:0]       idx4_ff;
   logic             v4_ff;

   always_comb begin
      logic [24:0] a;
      for (int j = 0; j < 3; j++) begin
         a         = vals3_ff[j][24] ? 25'(-$signed(vals3_ff[j])) : vals3_ff[j];
         sq4_in[j] = 48'(a[23:0]) * 48'(a[23:0]);
      end
   end

   // stage 5: sum of squares
   logic [49:0]   sum5_in, sum5_ff;
   val_type [2:0] vals5_ff;
   logic [1:0]    idx5_ff;
   logic          v5_ff;

   assign sum5_in = 50'(sq4_ff[0]) + 50'(sq4_ff[1]) + 50'(sq4_ff[2]);

   // stage 6: radicand of the dropped component
   logic [45:0]   rad6_in, rad6_ff;
   val_type [2:0] vals6_ff;
   logic [1:0]    idx6_ff;
   logic          v6_ff;

   assign rad6_in = (sum5_ff < ONE_SQ) ? 46'(ONE_SQ - sum5_ff) : '0;

   // dropped component root
   logic          r1_valid;
   logic [22:0]   r1_root;
   logic [76:0]   r1_side;
   logic [1:0]    r1_idx;
   val_type [2:0] r1_vals;

   stqd_sqrt #(
      .W  (46),
      .SW (77)
   ) u_drop_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v6_ff),
      .in_rad    (rad6_ff),
      .in_side   ({idx6_ff, vals6_ff}),
      .out_valid (r1_valid),
      .out_root  (r1_root),
      .out_side  (r1_side)
   );

   assign {r1_idx, r1_vals} = r1_side;

   // stage 7: place the rebuilt component, retained ones keep their order
   val_type [3:0] comps7_in, comps7_ff;
   logic          v7_ff;

   always_comb begin
      val_type root;
      root = {2'b00, r1_root};
      unique case (r1_idx)
         2'd0: comps7_in = {r1_vals[2], r1_vals[1], r1_vals[0], root};
         2'd1: comps7_in = {r1_vals[2], r1_vals[1], root, r1_vals[0]};
         2'd2: comps7_in = {r1_vals[2], root, r1_vals[1], r1_vals[0]};
         2'd3: comps7_in = {root, r1_vals[2], r1_vals[1], r1_vals[0]};
      endcase
   end

   // stage 8: squares of all four
   logic [3:0][47:0] csq8_in, csq8_ff;
   val_type [3:0]    comps8_ff;
   logic             v8_ff;

   always_comb begin
      logic [24:0] a;
      for (int j = 0; j < 4; j++) begin
         a          = comps7_ff[j][24] ? 25'(-$signed(comps7_ff[j])) : comps7_ff[j];
         csq8_in[j] = 48'(a[23:0]) * 48'(a[23:0]);
      end
   end

   // stage 9: length squared
   logic [49:0]   lensq9_in, lensq9_ff;
   val_type [3:0] comps9_ff;
   logic          v9_ff;

   assign lensq9_in = 50'(csq8_ff[0]) + 50'(csq8_ff[1]) + 50'(csq8_ff[2]) + 50'(csq8_ff[3]);

   // stage 10: length radicand in Q4.58 and renormalize decision
   logic [63:0]   rad10_in, rad10_ff;
   logic          big10_in, big10_ff;
   val_type [3:0] comps10_ff;
   logic          v10_ff;

   assign rad10_in = {lensq9_ff, 14'd0};
   assign big10_in = lensq9_ff > RENORM_MIN;

   // length root, Q2.29
   logic          r2_valid;
   logic [31:0]   r2_root;
   logic [100:0]  r2_side;
   logic          r2_big;
   val_type [3:0] r2_comps;

   stqd_sqrt #(
      .W  (64),
      .SW (101)
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v10_ff),
      .in_rad    (rad10_ff),
      .in_side   ({big10_ff, comps10_ff}),
      .out_valid (r2_valid),
      .out_root  (r2_root),
      .out_side  (r2_side)
   );

   assign {r2_big, r2_comps} = r2_side;

   // stage 11: normalize by length, or plain rescale when the length is tiny
   logic [3:0][46:0] n11_in, n11_ff;
   logic [3:0][30:0] d11_in, d11_ff;
   logic [3:0]       neg11_in, neg11_ff;
   logic             v11_ff;

   always_comb begin
      logic [24:0] a;
      for (int j = 0; j < 4; j++) begin
         a           = r2_comps[j][24] ? 25'(-$signed(r2_comps[j])) : r2_comps[j];
         neg11_in[j] = r2_comps[j][24];
         if (r2_big) begin
            n11_in[j] = 47'({a[23:0], 22'd0}) + 47'(r2_root[31:1]);
            d11_in[j] = r2_root[30:0];
         end else begin
            n11_in[j] = 47'(a[23:0]) + 47'd64;
            d11_in[j] = 31'd128;
         end
      end
   end

   // normalizing divider
   logic             q2_valid;
   logic [3:0][16:0] q2_quo;
   logic [3:0]       q2_neg;

   stqd_div #(
      .LANES (4),
      .NW    (47),
      .DW    (31),
      .QW    (17),
      .SW    (4)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (v11_ff),
      .in_num    (n11_ff),
      .in_den    (d11_ff),
      .in_side   (neg11_ff),
      .out_valid (q2_valid),
      .out_quo   (q2_quo),
      .out_side  (q2_neg)
   );

   // result stage: sign, z negate unless skipped, saturate to Q1.15
   logic [3:0][15:0] rsp_q_in, rsp_q_ff;

   always_comb begin
      logic signed [17:0] r;
      for (int j = 0; j < 4; j++) begin
         r = q2_neg[j] ? -$signed({1'b0, q2_quo[j]}) : $signed({1'b0, q2_quo[j]});
         if (j == 2 && !skip_z_ff) r = -r;
         if (r > 18'sd32767) rsp_q_in[j] = 16'h7FFF;
         else if (r < -18'sd32768) rsp_q_in[j] = 16'h8000;
         else rsp_q_in[j] = r[15:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= q1_valid;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= r1_valid;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= v9_ff;
         v11_ff       <= r2_valid;
         rsp_valid_ff <= q2_valid;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff    <= num1_in;
         den1_ff    <= den1_in;
         idx1_ff    <= idx1_in;
         nmag2_ff   <= nmag2_in;
         den2_ff    <= den1_ff;
         neg2_ff    <= neg2_in;
         idx2_ff    <= idx1_ff;
         vals3_ff   <= vals3_in;
         idx3_ff    <= q1_idx;
         sq4_ff     <= sq4_in;
         vals4_ff   <= vals3_ff;
         idx4_ff    <= idx3_ff;
         sum5_ff    <= sum5_in;
         vals5_ff   <= vals4_ff;
         idx5_ff    <= idx4_ff;
         rad6_ff    <= rad6_in;
         vals6_ff   <= vals5_ff;
         idx6_ff    <= idx5_ff;
         comps7_ff  <= comps7_in;
         csq8_ff    <= csq8_in;
         comps8_ff  <= comps7_ff;
         lensq9_ff  <= lensq9_in;
         comps9_ff  <= comps8_ff;
         rad10_ff   <= rad10_in;
         big10_ff   <= big10_in;
         comps10_ff <= comps9_ff;
         n11_ff     <= n11_in;
         d11_ff     <= d11_in;
         neg11_ff   <= neg11_in;
         rsp_q_ff   <= rsp_q_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = rsp_q_ff[0];
   assign rsp_quat_y = rsp_q_ff[1];
   assign rsp_quat_z = rsp_q_ff[2];
   assign rsp_quat_w = rsp_q_ff[3];

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v11_ff) && $stable(r2_valid) && $stable(v3_ff))
      else $error("pipeline moved while held");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      r1_valid |-> r1_root <= 23'h400000)
      else $error("rebuilt component above one");

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      r2_valid && r2_big |-> r2_root != 32'd0)
      else $error("normalizing by zero length");

endmodule

[test/tb_smallest_three_quaternion_decode.sv]
`timescale 1ns / 100ps

module tb_smallest_three_quaternion_decode;
   import stqd_pkg::*;

   localparam longint K_FIX = 2965821;
   localparam longint ONE_Q44 = 64'd1 << 44;
   localparam longint RENORM_FLOOR = 175921;
   localparam int LATENCY = 108;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } quat_type;

   // decoder settings mirrored from the register writes
   logic [1:0] cur_layout;
   logic [7:0] cur_ctx_a, cur_ctx_b, cur_ctx_c;
   logic       cur_skip_z;
   logic [2:0] cur_axis;

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint floor_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // base plus or minus scaled magnitude from the context table, in Q2.22
   function automatic longint context_value(logic [7:0] ctx, bit neg, int mag, longint d);
      int c, lvl;
      longint span, k, num;
      c = ctx;
      if (c < CTX_LOW) c = CTX_LOW;
      if (c > CTX_HIGH) c = CTX_HIGH;
      if (c >= 'hFC) lvl = 1;
      else if (c >= 'hF8) lvl = 2;
      else if (c >= 'hF0) lvl = 3;
      else if (c >= 'hE0) lvl = 4;
      else if (c >= 'hC0) lvl = 5;
      else lvl = 6;
      span = 64'd1 << lvl;
      k = c - (256 - 2 * span);
      num = (2 * k - span + 1) * d + (neg ? -2 * mag : 2 * mag);
      return round_div(num * 4194304, (span + 1) * d);
   endfunction

   function automatic logic signed [15:0] sat_q15(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic quat_type decode_rotation(logic [31:0] word);
      longint vals[3], comps[4], s, sum, lensq, n;
      int drop, src, f;
      quat_type q;
      sum = 0;
      lensq = 0;
      src = 0;
      if (cur_layout == LAYOUT_TABLE) begin
         drop = cur_axis[2] ? 3 : cur_axis[1:0];
         vals[0] = context_value(cur_ctx_a, word[31], word[30:21], 511);
         vals[1] = context_value(cur_ctx_b, word[20], word[19:10], 511);
         vals[2] = context_value(cur_ctx_c, word[9], word[8:0], 1023);
      end else if (cur_layout == LAYOUT_SIGNED) begin
         drop = word[1:0];
         for (int j = 0; j < 3; j++) begin
            f = (word >> (2 + 10 * j)) & 'h3ff;
            s = (f >= 512) ? f - 1024 : f;
            vals[j] = round_div(s * K_FIX, 512);
         end
      end else begin
         drop = word[31:30];
         for (int j = 0; j < 3; j++) begin
            f = (word >> (10 * j)) & 'h3ff;
            vals[j] = round_div((2 * longint'(f) - 1023) * K_FIX, 1023);
         end
      end
      for (int j = 0; j < 3; j++) sum += vals[j] * vals[j];
      for (int i = 0; i < 4; i++) begin
         if (i == drop) comps[i] = (sum < ONE_Q44) ? floor_sqrt(ONE_Q44 - sum) : 0;
         else begin
            comps[i] = vals[src];
            src++;
         end
         lensq += comps[i] * comps[i];
      end
      if (lensq > RENORM_FLOOR) begin
         n = floor_sqrt(lensq << 14);
         for (int i = 0; i < 4; i++) comps[i] = round_div(comps[i] * 4194304, n);
      end else begin
         for (int i = 0; i < 4; i++) comps[i] = round_div(comps[i], 128);
      end
      if (!cur_skip_z) comps[2] = -comps[2];
      q.x = sat_q15(comps[0]);
      q.y = sat_q15(comps[1]);
      q.z = sat_q15(comps[2]);
      q.w = sat_q15(comps[3]);
      return q;
   endfunction

   // expected quaternions in transfer order
   class quat_scoreboard;
      quat_type pending[$];
      int errors = 0;

      function void note_word(logic [31:0] word);
         pending = {pending, decode_rotation(word)};
      endfunction

      function void check_quat(quat_type got);
         quat_type exp_q;
         if (pending.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         exp_q = pending[0];
         pending.delete(0);
         if (got.x !== exp_q.x) begin
            $error("quat_x expected %0d actual %0d", exp_q.x, got.x);
            errors++;
         end
         if (got.y !== exp_q.y) begin
            $error("quat_y expected %0d actual %0d", exp_q.y, got.y);
            errors++;
         end
         if (got.z !== exp_q.z) begin
            $error("quat_z expected %0d actual %0d", exp_q.z, got.z);
            errors++;
         end
         if (got.w !== exp_q.w) begin
            $error("quat_w expected %0d actual %0d", exp_q.w, got.w);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_packed_rotation = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic csr_write = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   quat_scoreboard board = new();
   bit stall_idle = 0;
   int rsp_wait = 0;

   smallest_three_quaternion_decode dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result side: random wait per item unless stall_idle is set, check on each transfer
   always @(posedge clock) begin
      quat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_quat_x;
         got.y = rsp_quat_y;
         got.z = rsp_quat_z;
         got.w = rsp_quat_w;
         board.check_quat(got);
         rsp_wait = stall_idle ? 0 : $urandom_range(0, 4);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_stall <= (rsp_wait != 0);
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         REG_LAYOUT: cur_layout = val[1:0];
         REG_CTX_A: cur_ctx_a = val;
         REG_CTX_B: cur_ctx_b = val;
         REG_CTX_C: cur_ctx_c = val;
         REG_SKIP_Z: cur_skip_z = val[0];
         REG_FORCE_AXIS: cur_axis = val[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one input transfer, with a random gap first in burst-free mode
   task automatic send_word(logic [31:0] word, bit allow_gap);
      int gap;
      gap = allow_gap ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_packed_rotation <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_word(word);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic random_words(int count);
      bit bursty;
      bursty = 1'($urandom_range(0, 1));
      for (int i = 0; i < count; i++) begin
         logic [31:0] word;
         word = $urandom();
         if (i % 50 == 0) bursty = 1'($urandom_range(0, 1));
         // unit component and zero-ish words now and then
         case ($urandom_range(0, 9))
            0: word = 32'h0;
            1: word = 32'hffffffff;
            2: word[29:0] = {3{10'h200}};
            default: ;
         endcase
         send_word(word, !bursty);
      end
   endtask

   // the two limits of the word, the two words around its midpoint, its four index settings and two more words
   task automatic directed_words;
      send_word(32'h00000000, 1'b0);
      send_word(32'hffffffff, 1'b0);
      send_word(32'h7fffffff, 1'b1);
      send_word(32'h80000000, 1'b0);
      for (int d = 0; d < 4; d++) begin
         send_word({d[1:0], 30'h1ff7fdff}, 1'b0);
         send_word({30'h200801ff, d[1:0]}, 1'b1);
         send_word({d[1:0], 30'h0}, 1'b0);
      end
      send_word(32'h40100401, 1'b0);
      send_word(32'h3ff003ff, 1'b0);
   endtask

   initial begin
      int settings;
      cur_layout = LAYOUT_TABLE;
      cur_ctx_a = CTX_RESET;
      cur_ctx_b = CTX_RESET;
      cur_ctx_c = CTX_RESET;
      cur_skip_z = 0;
      cur_axis = AXIS_RESET;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults first, then every layout, with the z option alternating between layouts
      directed_words();
      drain();
      for (int lay = 0; lay < 4; lay++) begin
         write_reg(REG_LAYOUT, 8'(lay));
         write_reg(REG_SKIP_Z, 8'(lay[0]));
         write_reg(REG_FORCE_AXIS, 8'(lay + 1));
         directed_words();
         drain();
      end
      // out of range register index leaves everything unchanged
      write_reg(3'd7, 8'hff);
      write_reg(3'd6, 8'h00);

      // table extremes: contexts at clamp ends and on level boundaries
      write_reg(REG_LAYOUT, 8'(LAYOUT_TABLE));
      write_reg(REG_CTX_A, 8'h00);
      write_reg(REG_CTX_B, 8'hff);
      write_reg(REG_CTX_C, CTX_LOW);
      write_reg(REG_FORCE_AXIS, 8'd4);
      directed_words();
      drain();
      write_reg(REG_CTX_A, CTX_HIGH);
      write_reg(REG_CTX_B, 8'hc0);
      write_reg(REG_CTX_C, 8'hfc);
      write_reg(REG_FORCE_AXIS, 8'd0);
      directed_words();
      drain();

      // random phases across random settings
      for (settings = 0; settings < 16; settings++) begin
         write_reg(REG_LAYOUT, 8'($urandom_range(0, 3)));
         write_reg(REG_CTX_A, 8'($urandom_range(0, 255)));
         write_reg(REG_CTX_B, 8'($urandom_range(140, 255)));
         write_reg(REG_CTX_C, 8'($urandom_range(150, 255)));
         write_reg(REG_SKIP_Z, 8'($urandom_range(0, 1)));
         write_reg(REG_FORCE_AXIS, 8'($urandom_range(0, 7)));
         stall_idle = (settings % 5 == 4);
         random_words(100);
         drain();
      end

      stall_idle = 1;
      drain();
      if (board.errors == 0 && board.pending.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[smallest_three_quaternion_decode.f]
rtl/stqd_pkg.sv
rtl/stqd_div.sv
rtl/stqd_sqrt.sv
rtl/smallest_three_quaternion_decode.sv
test/tb_smallest_three_quaternion_decode.sv
